[sv/fcb_pkg.sv]
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types and constants of the fault code beeper.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int FAULT_SLOTS = 16;
  localparam int FLAG_W      = 16;
  localparam int SCAN_SLOTS  = (FAULT_SLOTS < FLAG_W) ? FAULT_SLOTS : FLAG_W;
  localparam int CODE_W      = 5;
  localparam int HALF_W      = 7;
  localparam int PAUSE_W     = 8;
  localparam int PHASE_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FLAG_W-1:0]  MASK_RESET  = '1;
  localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(50);
  localparam logic [PAUSE_W-1:0] PAUSE_RESET = PAUSE_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_MASK  = 2'd0,
    CFG_HALF_PERIOD  = 2'd1,
    CFG_PAUSE_LENGTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              buzzer;
    logic [CODE_W-1:0] beeps;
  } burst_t;

endpackage

[sv/fault_code_beeper.sv]
// ----------------------------------------------------------------------------
// fault_code_beeper
// Sounds the number of the lowest enabled active fault as a burst of beeps.
// ----------------------------------------------------------------------------
// Each input beat is one tick of fault flags and yields exactly one result
// beat: buzzer level, fault code and beeps left. One beat is taken per
// clock cycle unless the output stalls; a result passes through the input
// register and the result register around the single update stage.
// Configuration writes take effect at once and belong between items only.
module fault_code_beeper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fcb_pkg::FLAG_W-1:0]     fault_flags_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           tone_on_o,
  output logic [fcb_pkg::CODE_W-1:0]     fault_code_o,
  output logic [fcb_pkg::CODE_W-1:0]     beeps_left_o
);
  import fcb_pkg::*;

  logic [FLAG_W-1:0]  mask_q;
  logic [HALF_W-1:0]  half_q;
  logic [PAUSE_W-1:0] pause_q;

  logic              in_valid_q;
  logic [FLAG_W-1:0] flags_q;
  logic              out_valid_q;
  logic              buzz_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] beeps_q;

  logic              out_free;
  logic              advance;
  logic [CODE_W-1:0] code;
  burst_t            burst;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= MASK_RESET;
      half_q  <= HALF_RESET;
      pause_q <= PAUSE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE_MASK:  mask_q  <= cfg_data_i[FLAG_W-1:0];
        CFG_HALF_PERIOD:  half_q  <= cfg_data_i[HALF_W-1:0];
        CFG_PAUSE_LENGTH: pause_q <= cfg_data_i[PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      flags_q <= fault_flags_i;
    end
  end

  fcb_prio_enc u_prio_enc (
    .flags_i (flags_q),
    .mask_i  (mask_q),
    .code_o  (code)
  );

  fcb_burst u_burst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .code_i         (code),
    .half_period_i  (half_q),
    .pause_length_i (pause_q),
    .burst_o        (burst)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      buzz_q  <= burst.buzzer;
      code_q  <= code;
      beeps_q <= burst.beeps;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tone_on_o    = buzz_q;
  assign fault_code_o = code_q;
  assign beeps_left_o = beeps_q;

endmodule

[sv/fcb_prio_enc.sv]
// ----------------------------------------------------------------------------
// fcb_prio_enc
// Finds the lowest enabled active fault slot and returns its index plus one.
// ----------------------------------------------------------------------------
module fcb_prio_enc (
  input  logic [fcb_pkg::FLAG_W-1:0] flags_i,
  input  logic [fcb_pkg::FLAG_W-1:0] mask_i,
  output logic [fcb_pkg::CODE_W-1:0] code_o
);
  import fcb_pkg::*;

  logic [FLAG_W-1:0] live;

  assign live = flags_i & mask_i;

  // scan from the top so the lowest slot wins
  always_comb begin
    code_o = '0;
    for (int i = SCAN_SLOTS - 1; i >= 0; i--) begin
      if (live[i]) begin
        code_o = CODE_W'(i + 1);
      end
    end
  end

endmodule

[sv/fcb_burst.sv]
// ----------------------------------------------------------------------------
// fcb_burst
// Pause, burst load and beep counters; gives the updated buzzer level and
// pending beep count for the tick being processed.
// ----------------------------------------------------------------------------
module fcb_burst (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [fcb_pkg::CODE_W-1:0]  code_i,
  input  logic [fcb_pkg::HALF_W-1:0]  half_period_i,
  input  logic [fcb_pkg::PAUSE_W-1:0] pause_length_i,
  output fcb_pkg::burst_t             burst_o
);
  import fcb_pkg::*;

  logic               buzz_q,  buzz_d;
  logic               seen_q,  seen_d;
  logic [CODE_W-1:0]  beeps_q, beeps_d;
  logic [PAUSE_W-1:0] pause_q, pause_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W-1:0] phase_inc;

  assign phase_inc = phase_q + PHASE_W'(1);

  always_comb begin
    buzz_d  = buzz_q;
    seen_d  = seen_q;
    beeps_d = beeps_q;
    pause_d = pause_q;
    phase_d = phase_q;
    if (step_i) begin
      if (code_i == '0) begin
        if (seen_q) begin
          buzz_d = 1'b0;
        end
      end else if (beeps_q == '0 && pause_q == '0) begin
        beeps_d = code_i;
        pause_d = pause_length_i;
      end else if (beeps_q == '0) begin
        pause_d = pause_q - PAUSE_W'(1);
        buzz_d  = 1'b0;
      end else begin
        phase_d = phase_inc;
        if (phase_inc < PHASE_W'(half_period_i)) begin
          buzz_d = 1'b0;
        end else if (phase_inc < PHASE_W'({half_period_i, 1'b0})) begin
          buzz_d = 1'b1;
        end else begin
          phase_d = '0;
          beeps_d = beeps_q - CODE_W'(1);
        end
      end
      seen_d = (code_i != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buzz_q  <= 1'b0;
      seen_q  <= 1'b0;
      beeps_q <= '0;
      pause_q <= PAUSE_RESET;
      phase_q <= '0;
    end else begin
      buzz_q  <= buzz_d;
      seen_q  <= seen_d;
      beeps_q <= beeps_d;
      pause_q <= pause_d;
      phase_q <= phase_d;
    end
  end

  assign burst_o.buzzer = buzz_d;
  assign burst_o.beeps  = beeps_d;

`ifndef SYNTH
  a_hold_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && code_i == '0 |=> $stable(beeps_q) && $stable(pause_q) && $stable(phase_q))
    else $error("counters moved on a tick without fault");

  a_beeps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beeps_q <= CODE_W'(SCAN_SLOTS))
    else $error("pending beeps beyond slot count");

  a_sound_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(buzz_q) |-> beeps_q != '0)
    else $error("buzzer sounded outside a burst");

  a_pause_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && code_i != '0 && beeps_q == '0 && pause_q != '0 |=> !buzz_q)
    else $error("buzzer on during pause");
`endif

endmodule
